FILE: rtl/core/bmp_pkg.sv
package bmp_pkg;

   localparam int unsigned MAX_DIMENSION_DEFAULT = 4096;
   localparam longint unsigned MAX_PIXELS_DEFAULT = 64'd16777216;

   localparam logic [31:0] HEADER_BYTES = 32'd54;
   localparam logic [31:0] DIB_SIZE_V3  = 32'd40;
   localparam logic [7:0]  MAGIC_B      = 8'h42;
   localparam logic [7:0]  MAGIC_M      = 8'h4D;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FORMAT   = 3'd1;
   localparam logic [2:0] ST_HEADER   = 3'd2;
   localparam logic [2:0] ST_DIMS     = 3'd3;
   localparam logic [2:0] ST_BYTE_CNT = 3'd4;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // one result item
   typedef struct packed {
      logic        item_kind;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [2:0]  status;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        last_item;
   } result_type;

   // one classified byte from front to back
   typedef struct packed {
      logic        emit_pixel;
      logic        emit_status;
      result_type  pixel;
      result_type  stat;
   } work_type;

endpackage

FILE: rtl/core/bmp_front.sv
module bmp_front #(
   parameter int unsigned MAX_DIMENSION = bmp_pkg::MAX_DIMENSION_DEFAULT,
   parameter longint unsigned MAX_PIXELS = bmp_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_eof,
   output logic              wr_valid,
   input  logic              wr_ready,
   output bmp_pkg::work_type wr_data
);
   import bmp_pkg::*;

   // offset of the last header byte that carries a field
   localparam logic [31:0] FIELDS_LAST = 32'd37;

   logic [31:0] byte_count_ff, byte_count_in;
   logic [31:0] declared_ff, pixel_start_ff, dib_ff, width_ff, height_ff;
   logic [31:0] comp_ff, img_size_ff;
   logic [15:0] planes_ff, bpp_ff;
   logic        magic_ff;
   logic [11:0] col_ff, row_ff;
   logic [15:0] rbc_ff;
   logic [23:0] partial_ff;
   logic [1:0]  pbi_ff;

   // derived header values, registered while the rest of the header streams in
   logic [31:0] abs_h_ff;
   logic [31:0] row_bytes_ff, stride_ff;
   logic [63:0] expected_ff;
   logic        dims_ok_ff, format_ok_ff, isz_ok_ff, hdr_ok_ff;
   logic [2:0]  setup_ff;
   logic        bpp32_ff;

   logic        take;
   logic [31:0] abs_h_c;
   logic [63:0] area_c;

   assign in_ready = wr_ready;
   assign take = in_valid && in_ready;
   assign abs_h_c = height_ff[31] ? (32'd0 - height_ff) : height_ff;
   assign area_c = 64'(width_ff) * 64'(abs_h_ff);

   // header pipeline after the last field byte (multiplies spread over cycles)
   always_ff @(posedge clock) begin
      if (reset || (take && in_eof)) begin
         setup_ff <= 3'd0;
         abs_h_ff <= '0; bpp32_ff <= 1'b0; row_bytes_ff <= '0; stride_ff <= '0;
         expected_ff <= '0; dims_ok_ff <= 1'b0; format_ok_ff <= 1'b0;
         isz_ok_ff <= 1'b0; hdr_ok_ff <= 1'b0;
      end else begin
         if (take && byte_count_ff == FIELDS_LAST) begin
            setup_ff <= 3'd1;
         end else if (setup_ff != 3'd0) begin
            setup_ff <= (setup_ff == 3'd4) ? 3'd0 : setup_ff + 3'd1;
         end
         unique case (setup_ff)
            3'd1: begin
               abs_h_ff     <= abs_h_c;
               bpp32_ff     <= (bpp_ff == 16'd32);
               row_bytes_ff <= width_ff * 32'(bpp_ff[15:3]);
               format_ok_ff <= planes_ff == 16'd1 && comp_ff == 32'd0 &&
                               (bpp_ff == 16'd24 || bpp_ff == 16'd32);
            end
            3'd2: begin
               stride_ff  <= (row_bytes_ff + 32'd3) & ~32'd3;
               dims_ok_ff <= width_ff != 32'd0 && width_ff <= 32'(MAX_DIMENSION) &&
                             abs_h_ff != 32'd0 && abs_h_ff <= 32'(MAX_DIMENSION) &&
                             area_c <= 64'(MAX_PIXELS);
            end
            3'd3: begin
               expected_ff <= 64'(stride_ff) * 64'(abs_h_ff);
            end
            3'd4: begin
               isz_ok_ff  <= img_size_ff == 32'd0 || 64'(img_size_ff) == expected_ff;
               hdr_ok_ff  <= magic_ff && dib_ff == DIB_SIZE_V3 &&
                             pixel_start_ff >= HEADER_BYTES && dims_ok_ff && format_ok_ff &&
                             (img_size_ff == 32'd0 || 64'(img_size_ff) == expected_ff);
            end
            default: ;
         endcase
      end
   end

   // classify one byte
   logic        in_pix;
   logic [31:0] rel;
   logic        emit_p;
   logic [31:0] y_c;
   logic [2:0]  st_c;
   logic [15:0] rbc_next;
   logic [31:0] size_c;

   assign byte_count_in = (byte_count_ff == 32'hFFFF_FFFF) ? byte_count_ff
                                                           : byte_count_ff + 32'd1;
   assign rel = byte_count_ff - pixel_start_ff;
   assign size_c = byte_count_in;

   always_comb begin
      in_pix = byte_count_ff >= HEADER_BYTES && hdr_ok_ff &&
               byte_count_ff >= pixel_start_ff && 64'(rel) < expected_ff;
      emit_p = in_pix && 32'(rbc_ff) < row_bytes_ff &&
               !(32'(pbi_ff) + 32'd1 < (bpp32_ff ? 32'd4 : 32'd3));
      y_c = height_ff[31] ? 32'(row_ff) : (abs_h_ff - 32'd1 - 32'(row_ff));
      rbc_next = rbc_ff + 16'd1;
      // first failing check wins
      priority if (size_c < HEADER_BYTES || !magic_ff) st_c = ST_FORMAT;
      else if (declared_ff != size_c || dib_ff != DIB_SIZE_V3 ||
               pixel_start_ff < HEADER_BYTES) st_c = ST_HEADER;
      else if (!dims_ok_ff) st_c = ST_DIMS;
      else if (!format_ok_ff) st_c = ST_FORMAT;
      else if (!isz_ok_ff) st_c = ST_BYTE_CNT;
      else if (pixel_start_ff > size_c ||
               64'(size_c - pixel_start_ff) != expected_ff) st_c = ST_BYTE_CNT;
      else st_c = ST_OK;
   end

   always_comb begin
      wr_data = '0;
      wr_data.emit_pixel = emit_p;
      wr_data.emit_status = in_eof;
      wr_data.pixel.item_kind = KIND_PIXEL;
      wr_data.pixel.pixel_x = col_ff;
      wr_data.pixel.pixel_y = y_c[11:0];
      wr_data.pixel.blue  = partial_ff[7:0];
      wr_data.pixel.green = partial_ff[15:8];
      wr_data.pixel.red   = bpp32_ff ? partial_ff[23:16] : in_byte;
      wr_data.pixel.alpha = bpp32_ff ? in_byte : 8'hFF;
      wr_data.stat.item_kind = KIND_STATUS;
      wr_data.stat.status = st_c;
      wr_data.stat.last_item = 1'b1;
      if (st_c == ST_OK) begin
         wr_data.stat.image_width  = width_ff[12:0];
         wr_data.stat.image_height = abs_h_ff[12:0];
      end
   end
   assign wr_valid = take && (emit_p || in_eof);

   // update state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset || (take && in_eof)) begin
         byte_count_ff <= '0; declared_ff <= '0; pixel_start_ff <= '0; dib_ff <= '0;
         width_ff <= '0; height_ff <= '0; comp_ff <= '0; img_size_ff <= '0;
         planes_ff <= '0; bpp_ff <= '0; magic_ff <= 1'b0;
         col_ff <= '0; row_ff <= '0; rbc_ff <= '0; partial_ff <= '0; pbi_ff <= '0;
      end else if (take) begin
         byte_count_ff <= byte_count_in;
         if (byte_count_ff < HEADER_BYTES) begin
            // latch header fields little-endian
            unique case (byte_count_ff[5:0])
               6'd0: magic_ff <= in_byte == MAGIC_B;
               6'd1: magic_ff <= magic_ff && in_byte == MAGIC_M;
               6'd2: declared_ff[7:0] <= in_byte;
               6'd3: declared_ff[15:8] <= in_byte;
               6'd4: declared_ff[23:16] <= in_byte;
               6'd5: declared_ff[31:24] <= in_byte;
               6'd10: pixel_start_ff[7:0] <= in_byte;
               6'd11: pixel_start_ff[15:8] <= in_byte;
               6'd12: pixel_start_ff[23:16] <= in_byte;
               6'd13: pixel_start_ff[31:24] <= in_byte;
               6'd14: dib_ff[7:0] <= in_byte;
               6'd15: dib_ff[15:8] <= in_byte;
               6'd16: dib_ff[23:16] <= in_byte;
               6'd17: dib_ff[31:24] <= in_byte;
               6'd18: width_ff[7:0] <= in_byte;
               6'd19: width_ff[15:8] <= in_byte;
               6'd20: width_ff[23:16] <= in_byte;
               6'd21: width_ff[31:24] <= in_byte;
               6'd22: height_ff[7:0] <= in_byte;
               6'd23: height_ff[15:8] <= in_byte;
               6'd24: height_ff[23:16] <= in_byte;
               6'd25: height_ff[31:24] <= in_byte;
               6'd26: planes_ff[7:0] <= in_byte;
               6'd27: planes_ff[15:8] <= in_byte;
               6'd28: bpp_ff[7:0] <= in_byte;
               6'd29: bpp_ff[15:8] <= in_byte;
               6'd30: comp_ff[7:0] <= in_byte;
               6'd31: comp_ff[15:8] <= in_byte;
               6'd32: comp_ff[23:16] <= in_byte;
               6'd33: comp_ff[31:24] <= in_byte;
               6'd34: img_size_ff[7:0] <= in_byte;
               6'd35: img_size_ff[15:8] <= in_byte;
               6'd36: img_size_ff[23:16] <= in_byte;
               6'd37: img_size_ff[31:24] <= in_byte;
               default: ;
            endcase
         end else if (in_pix) begin
            if (32'(rbc_ff) < row_bytes_ff) begin
               if (emit_p) begin
                  partial_ff <= '0;
                  pbi_ff <= '0;
                  col_ff <= col_ff + 12'd1;
               end else begin
                  unique case (pbi_ff)
                     2'd0: partial_ff[7:0] <= in_byte;
                     2'd1: partial_ff[15:8] <= in_byte;
                     2'd2: partial_ff[23:16] <= in_byte;
                     default: ;
                  endcase
                  pbi_ff <= pbi_ff + 2'd1;
               end
            end
            // advance row at stride end
            if (32'(rbc_next) >= stride_ff) begin
               rbc_ff <= '0;
               row_ff <= row_ff + 12'd1;
               col_ff <= '0;
               pbi_ff <= '0;
               partial_ff <= '0;
            end else begin
               rbc_ff <= rbc_next;
            end
         end
      end
   end
endmodule

FILE: rtl/core/bmp_back.sv
module bmp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  bmp_pkg::work_type   wr_data,
   output logic                out_valid,
   input  logic                out_ready,
   output bmp_pkg::result_type out_data
);
   import bmp_pkg::*;

   localparam int unsigned DEPTH = 4;

   work_type    q_ff [DEPTH];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;
   logic        pix_done_ff;
   logic        pop, push;
   work_type    head;

   assign head = q_ff[rp_ff];
   assign wr_ready = cnt_ff < 3'(DEPTH);
   assign push = wr_valid && wr_ready;
   assign out_valid = cnt_ff != 3'd0;
   // pixel goes first, then status
   assign out_data = (head.emit_pixel && !pix_done_ff) ? head.pixel : head.stat;
   assign pop = out_valid && out_ready &&
                (!(head.emit_pixel && !pix_done_ff) || !head.emit_status);

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= wr_data;
   end

   // advance pointers and the split flag
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; pix_done_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) begin
            rp_ff <= rp_ff + 2'd1;
            pix_done_ff <= 1'b0;
         end else if (out_valid && out_ready) begin
            pix_done_ff <= 1'b1;
         end
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule

FILE: rtl/core/bmp_rgb_stream_decoder.sv
// Each result is registered in the output queue when its byte is accepted.
// Throughput: one byte per cycle while the output queue has room; the header
// multiplies settle after header byte 37 is accepted, so they never stall the input.
// A byte that ends a pixel and the file gives two results, the pixel first, then the status.
// Synchronous active-high reset clears all state; the end-of-file byte clears the header and pixel state too.
module bmp_rgb_stream_decoder #(
   parameter int unsigned MAX_DIMENSION = bmp_pkg::MAX_DIMENSION_DEFAULT,
   parameter longint unsigned MAX_PIXELS = bmp_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // pixel_x, pixel_y, red, green, blue, alpha,
                                    // status, image_width, image_height, zero fill
   output logic        rsp_tuser,   // item_kind
   output logic        rsp_tlast    // last_item
);
   import bmp_pkg::*;

   work_type   wr_data;
   logic       wr_valid, wr_ready;
   result_type res;

   bmp_front #(.MAX_DIMENSION(MAX_DIMENSION), .MAX_PIXELS(MAX_PIXELS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .in_eof(req_tlast),
      .wr_valid, .wr_ready, .wr_data
   );

   bmp_back u_back (
      .clock, .reset, .wr_valid, .wr_ready, .wr_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tuser = res.item_kind;
   assign rsp_tlast = res.last_item;
   assign rsp_tdata = {3'd0, res.image_height, res.image_width, res.status, res.alpha,
                       res.blue, res.green, res.red, res.pixel_y, res.pixel_x};
endmodule
